[design/http_date_parser_assert.svh]
// ---------------------------------------------------------------------------
// HTTP date parser assertion macros
// Wrappers for concurrent assertions, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef HTTP_DATE_PARSER_ASSERT_SVH
`define HTTP_DATE_PARSER_ASSERT_SVH
`ifndef SYNTH
`define HDP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HDP_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define HDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[design/hdp_pkg.sv]
// ---------------------------------------------------------------------------
// HTTP date parser package
// Shared constants, format codes and per-format parse state type.
// ---------------------------------------------------------------------------
package hdp_pkg;
   localparam int MaxYearDigitsDefault = 4;
   localparam int NumTok = 7;
   localparam logic [13:0] AccMax = 14'd16383;
   localparam logic [12:0] YearResetValue = 13'd126;

   localparam logic [1:0] FMT_RFC1123 = 2'd0;
   localparam logic [1:0] FMT_RFC850  = 2'd1;
   localparam logic [1:0] FMT_ASCTIME = 2'd2;

   localparam logic [1:0] K_WSHORT = 2'd0;
   localparam logic [1:0] K_WLONG  = 2'd1;
   localparam logic [1:0] K_MON    = 2'd2;
   localparam logic [1:0] K_NUM    = 2'd3;

   localparam logic [2:0] S_DAY  = 3'd0;
   localparam logic [2:0] S_YEAR = 3'd1;
   localparam logic [2:0] S_HOUR = 3'd2;
   localparam logic [2:0] S_MIN  = 3'd3;
   localparam logic [2:0] S_SEC  = 3'd4;

   typedef struct packed {
      logic [3:0]  phase;
      logic [3:0]  cnt;
      logic [6:0]  wk;
      logic [11:0] mon;
      logic        err;
      logic [13:0] day;
      logic [13:0] year;
      logic [13:0] hour;
      logic [13:0] mins;
      logic [13:0] secs;
   } fmt_state_type;

   typedef struct packed {
      logic [7:0] delim;
      logic [1:0] kind;
      logic [2:0] slot;
      logic       skip_sp;
   } tok_desc_type;

   function automatic tok_desc_type grammar(input logic [1:0] f, input logic [3:0] p);
      tok_desc_type d;
      d = '{delim: 8'h20, kind: K_NUM, slot: S_SEC, skip_sp: 1'b0};
      unique case (f)
         FMT_RFC1123: begin
            unique case (p)
               4'd0: d = '{8'h2C, K_WSHORT, S_DAY, 1'b1};
               4'd1: d = '{8'h20, K_NUM, S_DAY, 1'b0};
               4'd2: d = '{8'h20, K_MON, S_DAY, 1'b0};
               4'd3: d = '{8'h20, K_NUM, S_YEAR, 1'b0};
               4'd4: d = '{8'h3A, K_NUM, S_HOUR, 1'b0};
               4'd5: d = '{8'h3A, K_NUM, S_MIN, 1'b0};
               default: d = '{8'h20, K_NUM, S_SEC, 1'b0};
            endcase
         end
         FMT_RFC850: begin
            unique case (p)
               4'd0: d = '{8'h2C, K_WLONG, S_DAY, 1'b1};
               4'd1: d = '{8'h2D, K_NUM, S_DAY, 1'b1};
               4'd2: d = '{8'h2D, K_MON, S_DAY, 1'b0};
               4'd3: d = '{8'h20, K_NUM, S_YEAR, 1'b0};
               4'd4: d = '{8'h3A, K_NUM, S_HOUR, 1'b0};
               4'd5: d = '{8'h3A, K_NUM, S_MIN, 1'b0};
               default: d = '{8'h20, K_NUM, S_SEC, 1'b0};
            endcase
         end
         default: begin
            unique case (p)
               4'd0: d = '{8'h20, K_WSHORT, S_DAY, 1'b1};
               4'd1: d = '{8'h20, K_MON, S_DAY, 1'b0};
               4'd2: d = '{8'h20, K_NUM, S_DAY, 1'b0};
               4'd3: d = '{8'h3A, K_NUM, S_HOUR, 1'b0};
               4'd4: d = '{8'h3A, K_NUM, S_MIN, 1'b0};
               4'd5: d = '{8'h20, K_NUM, S_SEC, 1'b0};
               default: d = '{8'h20, K_NUM, S_YEAR, 1'b0};
            endcase
         end
      endcase
      return d;
   endfunction

   // Character of a long weekday name at a position; zero past the end.
   function automatic logic [7:0] wk_long_char(input int i, input logic [3:0] pos);
      logic [71:0] s;
      logic [3:0]  len;
      unique case (i)
         0: begin s = "Sunday   "; len = 4'd6; end
         1: begin s = "Monday   "; len = 4'd6; end
         2: begin s = "Tuesday  "; len = 4'd7; end
         3: begin s = "Wednesday"; len = 4'd9; end
         4: begin s = "Thursday "; len = 4'd8; end
         5: begin s = "Friday   "; len = 4'd6; end
         default: begin s = "Saturday "; len = 4'd8; end
      endcase
      if (pos >= len) return 8'h00;
      return s[71 - 8 * pos -: 8];
   endfunction

   function automatic logic [3:0] wk_long_len(input int i);
      unique case (i)
         2: return 4'd7;
         3: return 4'd9;
         4, 6: return 4'd8;
         default: return 4'd6;
      endcase
   endfunction

   function automatic logic [23:0] wk_short_name(input int i);
      unique case (i)
         0: return "Sun";
         1: return "Mon";
         2: return "Tue";
         3: return "Wed";
         4: return "Thu";
         5: return "Fri";
         default: return "Sat";
      endcase
   endfunction

   function automatic logic [23:0] mon_name(input int i);
      unique case (i)
         0: return "Jan";
         1: return "Feb";
         2: return "Mar";
         3: return "Apr";
         4: return "May";
         5: return "Jun";
         6: return "Jul";
         7: return "Aug";
         8: return "Sep";
         9: return "Oct";
         10: return "Nov";
         default: return "Dec";
      endcase
   endfunction
endpackage

[design/hdp_if.sv]
// ---------------------------------------------------------------------------
// HTTP date parser channels
// Valid/ready channels for request bytes, results and the year register.
// ---------------------------------------------------------------------------
interface hdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface hdp_rsp_if;
   logic        valid;
   logic        ready;
   logic        date_ok;
   logic [1:0]  date_format;
   logic [12:0] years_since_1900;
   logic [3:0]  month_index;
   logic [4:0]  day_of_month;
   logic [4:0]  hour_value;
   logic [5:0]  minute_value;
   logic [5:0]  second_value;
   logic [2:0]  weekday_index;
   modport source (output valid, date_ok, date_format, years_since_1900, month_index,
                   day_of_month, hour_value, minute_value, second_value, weekday_index,
                   input ready);
   modport sink (input valid, date_ok, date_format, years_since_1900, month_index,
                 day_of_month, hour_value, minute_value, second_value, weekday_index,
                 output ready);
endinterface

interface hdp_csr_if;
   logic        valid;
   logic        ready;
   logic [12:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[design/hdp_fmt_step.sv]
// ---------------------------------------------------------------------------
// HTTP date parser format step
// Next-state logic of one format's token machine for one byte.
// ---------------------------------------------------------------------------
module hdp_fmt_step
   import hdp_pkg::*;
#(
   parameter logic [1:0] FMT = FMT_RFC1123,
   parameter int MAX_YEAR_DIGITS = MaxYearDigitsDefault
) (
   input  fmt_state_type cur,
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   output fmt_state_type nxt
);
   tok_desc_type d;
   tok_desc_type de;
   fmt_state_type s;
   logic        active;
   logic        ending;
   logic [13:0] acc;
   logic [17:0] acc_x10;
   logic [3:0]  pos;
   logic        digit;
   logic [23:0] nm;

   // Marks a token finished: length check on names, digit count on the year.
   function automatic fmt_state_type close_tok(input fmt_state_type t, input tok_desc_type dd);
      fmt_state_type r;
      r = t;
      if (dd.kind == K_MON) begin
         if (t.cnt != 4'd3) r.mon = '0;
         if (r.mon == '0) r.err = 1'b1;
      end else if (dd.kind != K_NUM) begin
         for (int i = 0; i < 7; i++) begin
            if (((dd.kind == K_WLONG) ? wk_long_len(i) : 4'd3) != t.cnt) r.wk[i] = 1'b0;
         end
         if (r.wk == '0) r.err = 1'b1;
      end else if (dd.slot == S_YEAR && 32'(t.cnt) > MAX_YEAR_DIGITS) begin
         r.err = 1'b1;
      end
      r.phase = t.phase + 4'd1;
      r.cnt = '0;
      return r;
   endfunction

   always_comb begin
      s = cur;
      nm = '0;
      d = grammar(FMT, cur.phase);
      active = cur.phase < 4'(NumTok);
      pos = cur.cnt;
      digit = data_byte >= 8'h30 && data_byte <= 8'h39;
      unique case (d.slot)
         S_DAY:  acc = cur.day;
         S_YEAR: acc = cur.year;
         S_HOUR: acc = cur.hour;
         S_MIN:  acc = cur.mins;
         default: acc = cur.secs;
      endcase
      acc_x10 = {acc, 3'b000} + {2'b00, acc, 1'b0} + 18'(data_byte[3:0]);
      if (active) begin
         if (cur.cnt == '0 && (data_byte == d.delim || (d.skip_sp && data_byte == 8'h20))) begin
            s = cur;
         end else if (cur.cnt != '0 && data_byte == d.delim) begin
            s = close_tok(cur, d);
         end else begin
            if (cur.cnt != 4'd15) s.cnt = cur.cnt + 4'd1;
            if (d.kind == K_NUM) begin
               if (digit) begin
                  acc = (acc_x10 > 18'(AccMax)) ? AccMax : acc_x10[13:0];
                  unique case (d.slot)
                     S_DAY:  s.day = acc;
                     S_YEAR: s.year = acc;
                     S_HOUR: s.hour = acc;
                     S_MIN:  s.mins = acc;
                     default: s.secs = acc;
                  endcase
               end else begin
                  s.err = 1'b1;
               end
            end else if (d.kind == K_MON) begin
               for (int i = 0; i < 12; i++) begin
                  nm = mon_name(i);
                  if (pos >= 4'd3 || data_byte != nm[23 - 8 * pos[1:0] -: 8])
                     s.mon[i] = 1'b0;
               end
            end else begin
               for (int i = 0; i < 7; i++) begin
                  if (d.kind == K_WLONG) begin
                     if (pos >= wk_long_len(i) || data_byte != wk_long_char(i, pos))
                        s.wk[i] = 1'b0;
                  end else begin
                     nm = wk_short_name(i);
                     if (pos >= 4'd3 || data_byte != nm[23 - 8 * pos[1:0] -: 8])
                        s.wk[i] = 1'b0;
                  end
               end
            end
         end
      end
      // At the final byte close an open token, then require all tokens seen.
      nxt = s;
      de = grammar(FMT, s.phase);
      ending = last_byte && s.phase < 4'(NumTok) && s.cnt != '0;
      if (ending) nxt = close_tok(s, de);
      if (last_byte && nxt.phase < 4'(NumTok)) nxt.err = 1'b1;
   end
endmodule

[design/http_date_parser.sv]
// The result word for a value is registered and offered in the cycle after its last byte is taken.
// Throughput: one byte per cycle while req.ready is high; the three token machines update in a single pass.
// A one-deep result register may hold a word while parsing continues; req.ready drops
// only when that register is full, stalled, and the incoming byte is a last byte.
// Reset (synchronous, active high) clears the parse state and loads the year register to 126.
// ---------------------------------------------------------------------------
// HTTP date parser
// Parses RFC 1123, RFC 850 and asctime dates, one character per word.
// ---------------------------------------------------------------------------
module http_date_parser
   import hdp_pkg::*;
#(
   parameter int MAX_YEAR_DIGITS = MaxYearDigitsDefault
) (
   input  logic clock,
   input  logic reset,
   hdp_req_if.sink   req,
   hdp_rsp_if.source rsp,
   hdp_csr_if.sink   csr
);
   `include "http_date_parser_assert.svh"

   fmt_state_type st_ff [3];
   fmt_state_type st_in [3];
   fmt_state_type fin   [3];
   logic [7:0]  tail_ff;
   logic        gmt_ff, gmt_in, dash_ff, dash_in;
   logic [12:0] year_cfg_ff;
   logic        rsp_valid_ff;
   logic        take;
   logic        emit;
   logic [7:0]  prev_ff;

   // Result register.
   logic        ok_ff;
   logic [1:0]  fmt_ff;
   logic [12:0] ys_ff;
   logic [3:0]  mon_ff;
   logic [4:0]  day_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  min_ff;
   logic [5:0]  sec_ff;
   logic [2:0]  wk_ff;

   logic        ok_in;
   logic [1:0]  fmt_in;
   logic [13:0] year_sel, day_sel, hour_sel, min_sel, sec_sel;
   logic [14:0] ys_in;
   logic [3:0]  mon_in;
   logic [2:0]  wk_in;
   fmt_state_type sel;

   assign csr.ready = 1'b1;
   // A last byte may enter only if the result register is free or draining.
   assign req.ready = !rsp_valid_ff || rsp.ready || !req.last_byte;
   assign take = req.valid && req.ready;
   assign emit = take && req.last_byte;

   for (genvar f = 0; f < 3; f++) begin : g_fmt
      hdp_fmt_step #(.FMT(2'(f)), .MAX_YEAR_DIGITS(MAX_YEAR_DIGITS)) u_step (
         .cur(st_ff[f]),
         .data_byte(req.data_byte),
         .last_byte(req.last_byte),
         .nxt(fin[f])
      );
   end

   always_comb begin
      gmt_in = gmt_ff || (prev_ff == 8'h47 && tail_ff == 8'h4D && req.data_byte == 8'h54);
      dash_in = dash_ff || req.data_byte == 8'h2D;
      fmt_in = gmt_in ? (dash_in ? FMT_RFC850 : FMT_RFC1123) : FMT_ASCTIME;
      unique case (fmt_in)
         FMT_RFC1123: sel = fin[0];
         FMT_RFC850:  sel = fin[1];
         default:     sel = fin[2];
      endcase
      year_sel = sel.year;
      day_sel = sel.day;
      hour_sel = sel.hour;
      min_sel = sel.mins;
      sec_sel = sel.secs;
      ok_in = !sel.err;
      if (fmt_in == FMT_RFC850) begin
         ys_in = (15'(year_sel) + 15'd100 <= 15'(year_cfg_ff)) ? 15'(year_sel) + 15'd100
                                                                : 15'(year_sel);
      end else begin
         if (year_sel < 14'd1900) ok_in = 1'b0;
         ys_in = (year_sel >= 14'd1900) ? 15'(year_sel - 14'd1900) : '0;
      end
      if (ys_in > 15'd8099) ok_in = 1'b0;
      if (day_sel < 14'd1 || day_sel > 14'd31 || hour_sel > 14'd23 || min_sel > 14'd59 ||
          sec_sel > 14'd59) ok_in = 1'b0;
      mon_in = '0;
      for (int i = 11; i >= 0; i--) if (sel.mon[i]) mon_in = 4'(i);
      wk_in = '0;
      for (int i = 6; i >= 0; i--) if (sel.wk[i]) wk_in = 3'(i);
      for (int f = 0; f < 3; f++) begin
         st_in[f] = fin[f];
         if (req.last_byte) begin
            st_in[f] = '0;
            st_in[f].wk = '1;
            st_in[f].mon = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < 3; f++) begin
            st_ff[f] <= '{wk: '1, mon: '1, default: '0};
         end
         tail_ff <= '0;
         prev_ff <= '0;
         gmt_ff <= 1'b0;
         dash_ff <= 1'b0;
         year_cfg_ff <= YearResetValue;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) year_cfg_ff <= csr.data;
         if (take) begin
            for (int f = 0; f < 3; f++) st_ff[f] <= st_in[f];
            prev_ff <= req.last_byte ? 8'h00 : tail_ff;
            tail_ff <= req.last_byte ? 8'h00 : req.data_byte;
            gmt_ff <= req.last_byte ? 1'b0 : gmt_in;
            dash_ff <= req.last_byte ? 1'b0 : dash_in;
         end
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         ok_ff <= ok_in;
         fmt_ff <= fmt_in;
         ys_ff <= ok_in ? ys_in[12:0] : '0;
         mon_ff <= ok_in ? mon_in : '0;
         day_ff <= ok_in ? day_sel[4:0] : '0;
         hour_ff <= ok_in ? hour_sel[4:0] : '0;
         min_ff <= ok_in ? min_sel[5:0] : '0;
         sec_ff <= ok_in ? sec_sel[5:0] : '0;
         wk_ff <= ok_in ? wk_in : '0;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.date_ok = ok_ff;
   assign rsp.date_format = fmt_ff;
   assign rsp.years_since_1900 = ys_ff;
   assign rsp.month_index = mon_ff;
   assign rsp.day_of_month = day_ff;
   assign rsp.hour_value = hour_ff;
   assign rsp.minute_value = min_ff;
   assign rsp.second_value = sec_ff;
   assign rsp.weekday_index = wk_ff;

   `HDP_ASSERT_NEXT(a_emit_valid, clock, reset, emit, rsp_valid_ff, "result word not offered")
   `HDP_ASSERT_NEXT(a_clear_after_last, clock, reset, emit, !gmt_ff && !dash_ff, "not cleared")
   `HDP_ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid_ff && !ok_ff, ys_ff == '0, "bad error")
   `HDP_ASSERT_IMPL(a_fmt_code, clock, reset, rsp_valid_ff, fmt_ff != 2'd3, "bad format code")
endmodule

[tb/tb_http_date_parser.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// HTTP date parser testbench
// Drives header values byte by byte through three date forms and noise,
// predicts each result word, and checks it field by field.
// ---------------------------------------------------------------------------

typedef struct packed {
   logic        ok;
   logic [1:0]  fmt;
   logic [12:0] year;
   logic [3:0]  mon;
   logic [4:0]  day;
   logic [4:0]  hour;
   logic [5:0]  mins;
   logic [5:0]  secs;
   logic [2:0]  wday;
} date_word_type;

class date_scoreboard;
   localparam int Digits = hdp_pkg::MaxYearDigitsDefault;
   date_word_type pending_dates[$];
   int         errors;
   bit [12:0]  cur_year;
   bit [15:0]  tail;
   bit         gmt_seen, dash_seen;
   bit [3:0]   phase[3];
   bit [3:0]   cnt[3];
   bit [6:0]   wk[3];
   bit [11:0]  mon[3];
   bit         err[3];
   bit [13:0]  acc[3][5];

   function void clear();
      tail = 0; gmt_seen = 0; dash_seen = 0;
      for (int f = 0; f < 3; f++) begin
         phase[f] = 0; cnt[f] = 0; wk[f] = 7'h7F; mon[f] = 12'hFFF; err[f] = 0;
         for (int s = 0; s < 5; s++) acc[f][s] = 0;
      end
   endfunction

   function new();
      cur_year = 126;
      errors = 0;
      clear();
   endfunction

   // Token layout per form: delimiter, kind, number slot, space skipping.
   function void token_of(int f, int p, output byte dl, output int kd, output int sl,
                          output bit sk);
      string dls [3] = '{",   :: ", ",-- :: ", "   ::  "};
      int    kds [3][7] = '{'{0, 3, 2, 3, 3, 3, 3}, '{1, 3, 2, 3, 3, 3, 3},
                            '{0, 2, 3, 3, 3, 3, 3}};
      int    sls [3][7] = '{'{0, 0, 0, 1, 2, 3, 4}, '{0, 0, 0, 1, 2, 3, 4},
                            '{0, 0, 0, 2, 3, 4, 1}};
      dl = byte'(dls[f][p]);
      kd = kds[f][p]; sl = sls[f][p];
      sk = (p == 0) || (f == 1 && p == 1);
   endfunction

   function int long_len(int i);
      int l [7] = '{6, 6, 7, 9, 8, 6, 8};
      return l[i];
   endfunction

   function bit name_ok(int kd, int i, int pos, byte b);
      string wl [7] = '{"Sunday", "Monday", "Tuesday", "Wednesday", "Thursday",
                        "Friday", "Saturday"};
      string ws [7] = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};
      string mn [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun", "Jul", "Aug",
                         "Sep", "Oct", "Nov", "Dec"};
      if (kd == 1) return pos < long_len(i) && b == byte'(wl[i][pos]);
      if (kd == 0) return pos < 3 && b == byte'(ws[i][pos]);
      return pos < 3 && b == byte'(mn[i][pos]);
   endfunction

   function void close_token(int f);
      byte dl; int kd, sl; bit sk;
      token_of(f, phase[f], dl, kd, sl, sk);
      if (kd == 2) begin
         if (cnt[f] != 3) mon[f] = 0;
         if (mon[f] == 0) err[f] = 1;
      end else if (kd != 3) begin
         for (int i = 0; i < 7; i++)
            if ((kd == 1 ? long_len(i) : 3) != cnt[f]) wk[f][i] = 0;
         if (wk[f] == 0) err[f] = 1;
      end else if (sl == 1 && cnt[f] > Digits) err[f] = 1;
      phase[f]++;
      cnt[f] = 0;
   endfunction

   function void step_form(int f, byte b);
      byte dl; int kd, sl, pos; bit sk; int v;
      if (phase[f] >= 7) return;
      token_of(f, phase[f], dl, kd, sl, sk);
      if (cnt[f] == 0) begin
         if (b == dl || (sk && b == " ")) return;
      end else if (b == dl) begin
         close_token(f);
         return;
      end
      pos = cnt[f];
      if (cnt[f] < 15) cnt[f]++;
      if (kd == 3) begin
         if (b >= "0" && b <= "9") begin
            v = acc[f][sl] * 10 + (b - "0");
            acc[f][sl] = v > 16383 ? 14'(16383) : 14'(v);
         end else err[f] = 1;
      end else if (kd == 2) begin
         for (int i = 0; i < 12; i++) if (!name_ok(2, i, pos, b)) mon[f][i] = 0;
      end else begin
         for (int i = 0; i < 7; i++) if (!name_ok(kd, i, pos, b)) wk[f][i] = 0;
      end
   endfunction

   function int low_bit(bit [11:0] m);
      for (int i = 0; i < 12; i++) if (m[i]) return i;
      return 0;
   endfunction

   // Notes one accepted byte; queues a predicted date at the last byte.
   function void note_byte(byte b, bit last);
      int fm, ys; bit ok; date_word_type w;
      if (tail == {8'h47, 8'h4D} && b == "T") gmt_seen = 1;
      if (b == "-") dash_seen = 1;
      tail = {tail[7:0], b};
      for (int f = 0; f < 3; f++) step_form(f, b);
      if (!last) return;
      for (int f = 0; f < 3; f++) begin
         if (phase[f] < 7 && cnt[f] > 0) close_token(f);
         if (phase[f] < 7) err[f] = 1;
      end
      fm = gmt_seen ? (dash_seen ? 1 : 0) : 2;
      ok = !err[fm];
      if (fm == 1) ys = (acc[fm][1] + 100 <= cur_year) ? acc[fm][1] + 100 : acc[fm][1];
      else begin
         if (acc[fm][1] < 1900) ok = 0;
         ys = acc[fm][1] >= 1900 ? acc[fm][1] - 1900 : 0;
      end
      if (ys > 8099) ok = 0;
      if (acc[fm][0] < 1 || acc[fm][0] > 31 || acc[fm][2] > 23 || acc[fm][3] > 59 ||
          acc[fm][4] > 59) ok = 0;
      w = '0;
      w.ok = ok;
      w.fmt = 2'(fm);
      if (ok) begin
         w.year = 13'(ys); w.mon = 4'(low_bit(mon[fm])); w.day = 5'(acc[fm][0]);
         w.hour = 5'(acc[fm][2]); w.mins = 6'(acc[fm][3]); w.secs = 6'(acc[fm][4]);
         w.wday = 3'(low_bit({5'b0, wk[fm]}));
      end
      pending_dates.push_back(w);
      clear();
   endfunction

   function void check_date(date_word_type a);
      date_word_type e;
      if (pending_dates.size() == 0) begin
         $error("unexpected result word %h", a);
         errors++;
         return;
      end
      e = pending_dates.pop_front();
      if (a.ok !== e.ok) begin $error("date_ok exp %0d got %0d", e.ok, a.ok); errors++; end
      if (a.fmt !== e.fmt) begin
         $error("date_format exp %0d got %0d", e.fmt, a.fmt); errors++; end
      if (a.year !== e.year) begin
         $error("years_since_1900 exp %0d got %0d", e.year, a.year); errors++; end
      if (a.mon !== e.mon) begin
         $error("month_index exp %0d got %0d", e.mon, a.mon); errors++; end
      if (a.day !== e.day) begin
         $error("day_of_month exp %0d got %0d", e.day, a.day); errors++; end
      if (a.hour !== e.hour) begin
         $error("hour_value exp %0d got %0d", e.hour, a.hour); errors++; end
      if (a.mins !== e.mins) begin
         $error("minute_value exp %0d got %0d", e.mins, a.mins); errors++; end
      if (a.secs !== e.secs) begin
         $error("second_value exp %0d got %0d", e.secs, a.secs); errors++; end
      if (a.wday !== e.wday) begin
         $error("weekday_index exp %0d got %0d", e.wday, a.wday); errors++; end
   endfunction
endclass

module tb_http_date_parser;
   import hdp_pkg::*;

   logic clock = 0;
   logic reset = 1;
   hdp_req_if req ();
   hdp_rsp_if rsp ();
   hdp_csr_if csr ();

   date_scoreboard dates = new();
   int  send_idle_pct = 29, recv_idle_pct = 86;
   bit  hold_rsp = 0;
   longint cycles = 0;

   http_date_parser i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr));

   always #6 clock = ~clock;

   initial begin
      req.valid = 0; req.data_byte = 0; req.last_byte = 0;
      rsp.ready = 0; csr.valid = 0; csr.data = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: sample the word at the edge, then pick the next ready.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready)
            dates.check_date('{rsp.date_ok, rsp.date_format, rsp.years_since_1900,
                               rsp.month_index, rsp.day_of_month, rsp.hour_value,
                               rsp.minute_value, rsp.second_value, rsp.weekday_index});
         rsp.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Valid stays high between back-to-back words and drops only while idling.
   task automatic send_byte(byte b, bit last);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req.valid <= 1; req.data_byte <= b; req.last_byte <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      dates.note_byte(b, last);
   endtask

   task automatic send_value(string s);
      for (int i = 0; i < s.len(); i++) send_byte(byte'(s[i]), i == s.len() - 1);
   endtask

   task automatic write_year(bit [12:0] y);
      req.valid <= 0;
      while (dates.pending_dates.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr.valid <= 1; csr.data <= y;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 0;
      dates.cur_year = y;
   endtask

   function automatic string two(int v);
      return $sformatf("%02d", v);
   endfunction

   // Mostly well-formed dates of a random form, with some mangling.
   function automatic string random_date();
      string wl [7] = '{"Sunday", "Monday", "Tuesday", "Wednesday", "Thursday",
                        "Friday", "Saturday"};
      string ws [7] = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};
      string mn [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun", "Jul", "Aug",
                         "Sep", "Oct", "Nov", "Dec"};
      string s, t;
      int w = $urandom_range(6), m = $urandom_range(11);
      int d = $urandom_range(32), h = $urandom_range(25), mi = $urandom_range(61);
      int se = $urandom_range(61), y = $urandom_range(1850, 2200), p;
      if ($urandom_range(9) == 0) begin
         int n = $urandom_range(1, 12);
         s = "";
         for (int i = 0; i < n; i++) begin
            t = " "; t[0] = byte'($urandom_range(255)); s = {s, t};
         end
         return s;
      end
      case ($urandom_range(2))
         0: s = {ws[w], ", ", two(d), " ", mn[m], " ", $sformatf("%0d", y), " ", two(h), ":",
                 two(mi), ":", two(se), " GMT"};
         1: s = {wl[w], ", ", two(d), "-", mn[m], "-", two(y % 100), " ", two(h), ":",
                 two(mi), ":", two(se), " GMT"};
         default: s = {ws[w], " ", mn[m], " ", $sformatf("%2d", d), " ", two(h), ":",
                       two(mi), ":", two(se), " ", $sformatf("%0d", y)};
      endcase
      if ($urandom_range(2) == 0) s = {" ", s};
      if ($urandom_range(4) == 0) begin
         p = $urandom_range(s.len() - 1);
         s[p] = byte'($urandom_range(255));
      end
      return s;
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed values: each form, extremes, errors and high byte values.
      send_value("Sun, 06 Nov 1994 08:49:37 GMT");
      send_value("Sunday, 06-Nov-94 08:49:37 GMT");
      send_value("Sun Nov  6 08:49:37 1994");
      send_value("  Sat, 31 Dec 9999 23:59:59 GMT");
      send_value("Wednesday, 01-Jan-00 00:00:00 GMT");
      send_value("Mon, 00 Jan 1900 00:00:00 GMT");
      send_value("Tue, 01 Feb 19000 00:00:00 GMT");
      send_value("Thu Feb 29 24:60:60 1899");
      send_value("Fri, 1x Mar 2000 12:00:00 GMT");
      send_value("mon, 01 Jan 2000 00:00:00 GMT");
      send_value("Thursday, 01-May-2000 10:10:10 GMT extra text");
      send_value("Fri Jun 99999 00:00:00 2000");
      send_byte(8'h00, 0); send_byte(8'hFF, 0); send_byte(8'hAA, 0); send_byte(8'h55, 1);
      send_value("Friday, 15-Sep-70 01:02:03 GMT");
      write_year(0);
      send_value("Friday, 15-Sep-70 01:02:03 GMT");
      write_year(8191);
      send_value("Saturday, 15-Oct-99 01:02:03 GMT");
      write_year(126);
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 29 : (ph == 1 ? 86 : 0);
         recv_idle_pct = ph == 0 ? 86 : (ph == 1 ? 29 : 0);
         if (ph == 2) begin
            fork
               begin
                  hold_rsp = 1;
                  repeat (300) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         for (int k = 0; k < 4; k++) send_value(random_date());
         if (ph == 1) write_year($urandom_range(8099));
         if (ph == 2) write_year(126);
      end
      req.valid <= 0;
      while (dates.pending_dates.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (dates.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
